### src/gsps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gauge stepper sequencer package
// Shared widths, command kinds, the state record and the six-phase coil decode.
// ----------------------------------------------------------------------------
package gsps_pkg;

    localparam int KIND_W    = 2;
    localparam int VALUE_W   = 16;
    localparam int POS_W     = 10;
    localparam int PHASE_W   = 3;
    localparam int COIL_W    = 4;
    localparam int PCT_W     = 7;
    localparam int PERCENT_MAX = 100;
    localparam int LAST_PHASE  = 5;

    typedef enum logic [KIND_W-1:0] {
        KIND_PERCENT = 2'd0,
        KIND_STEPS   = 2'd1,
        KIND_TICK    = 2'd2,
        KIND_HOME    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   target;
        logic [POS_W-1:0]   homing_left;
        logic [COIL_W-1:0]  coil;
    } motor_state_t;

    // Coil pattern for a phase index; out-of-range codes decode as phase 0
    function automatic logic [COIL_W-1:0] phase_pins(input logic [PHASE_W-1:0] p);
        logic [COIL_W-1:0] pins;
        begin
            unique case (p)
                3'd1:    pins = 4'b0100;
                3'd2:    pins = 4'b1101;
                3'd3:    pins = 4'b1001;
                3'd4:    pins = 4'b1011;
                3'd5:    pins = 4'b0010;
                default: pins = 4'b0110;
            endcase
            return pins;
        end
    endfunction

    // Step the phase forward or back, wrapping over the six phases
    function automatic logic [PHASE_W-1:0] phase_step(input logic [PHASE_W-1:0] p,
                                                      input logic fwd);
        logic [PHASE_W-1:0] base;
        logic [PHASE_W-1:0] res;
        begin
            base = (p > PHASE_W'(LAST_PHASE)) ? '0 : p;
            if (fwd)
                res = (base == PHASE_W'(LAST_PHASE)) ? '0 : base + 1'b1;
            else
                res = (base == '0) ? PHASE_W'(LAST_PHASE) : base - 1'b1;
            return res;
        end
    endfunction

endpackage
`default_nettype wire

### src/gsps_step.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gauge stepper next-state logic
// Applies one command to the motor state: target load, tick or homing start.
// ----------------------------------------------------------------------------
module gsps_step
    import gsps_pkg::*;
#(
    parameter int FULL_SCALE_STEPS = 600
)
(
    input  wire motor_state_t       cur,
    input  wire kind_t              kind,
    input  wire logic [VALUE_W-1:0] value,
    output motor_state_t            nxt
);

    logic [PCT_W-1:0]   pct_clip;
    logic [POS_W-1:0]   pct_steps;
    logic [POS_W-1:0]   steps_clip;
    logic [POS_W-1:0]   homing_dec;
    logic [PHASE_W-1:0] phase_new;

    // Clip percent to 0..100, then scale by six with two shifts
    always_comb
    begin
        if (value[VALUE_W-1])
            pct_clip = '0;
        else if (value[VALUE_W-2:0] > (VALUE_W-1)'(PERCENT_MAX))
            pct_clip = PCT_W'(PERCENT_MAX);
        else
            pct_clip = value[PCT_W-1:0];
        pct_steps = {1'b0, pct_clip, 2'b00} + {2'b00, pct_clip, 1'b0};
    end

    // Clip step count to 0..full scale
    always_comb
    begin
        if (value[VALUE_W-1])
            steps_clip = '0;
        else if (value[VALUE_W-2:0] > (VALUE_W-1)'(FULL_SCALE_STEPS))
            steps_clip = POS_W'(FULL_SCALE_STEPS);
        else
            steps_clip = value[POS_W-1:0];
    end

    assign homing_dec = cur.homing_left - 1'b1;

    // Apply the command
    always_comb
    begin
        nxt       = cur;
        phase_new = '0;
        unique case (kind)
            KIND_PERCENT: nxt.target      = pct_steps;
            KIND_STEPS:   nxt.target      = steps_clip;
            KIND_HOME:    nxt.homing_left = POS_W'(FULL_SCALE_STEPS);
            default:
            begin
                if (cur.homing_left != '0)
                begin
                    phase_new       = phase_step(cur.phase, 1'b1);
                    nxt.phase       = phase_new;
                    nxt.coil        = phase_pins(phase_new);
                    nxt.homing_left = homing_dec;
                    if (homing_dec == '0)
                    begin
                        nxt.position = '0;
                        nxt.target   = '0;
                    end
                end
                else if (cur.position < cur.target)
                begin
                    phase_new    = phase_step(cur.phase, 1'b0);
                    nxt.phase    = phase_new;
                    nxt.coil     = phase_pins(phase_new);
                    nxt.position = cur.position + 1'b1;
                end
                else if (cur.position > cur.target)
                begin
                    phase_new    = phase_step(cur.phase, 1'b1);
                    nxt.phase    = phase_new;
                    nxt.coil     = phase_pins(phase_new);
                    nxt.position = cur.position - 1'b1;
                end
            end
        endcase
    end

endmodule
`default_nettype wire

### src/gauge_stepper_position_sequencer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gauge stepper position sequencer
// Six-phase coil sequencer that walks a tracked position toward a target.
// ----------------------------------------------------------------------------
// Every command transaction (set percent, set steps, tick, home) is applied to
// the motor state in the cycle it is accepted and yields one result
// transaction in the next cycle, carrying the coil pins, position, target and
// busy flag after the command. The block takes one command per clock; the
// output register is the only stage, and input is stalled only while a
// result sits unread in it with the downstream side not ready.
module gauge_stepper_position_sequencer_core
    import gsps_pkg::*;
#(
    parameter int FULL_SCALE_STEPS = 600
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [15:0] position_value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] kind
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata    // [3:0] coil_pins, [13:4] current_position,
                                             // [23:14] target_position, [24] busy_res
);

    motor_state_t state_reg;
    motor_state_t state_next;
    logic         out_valid_reg;
    logic [31:0]  out_data_reg;
    logic         in_acc;
    logic         busy_next;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    gsps_step #(
        .FULL_SCALE_STEPS (FULL_SCALE_STEPS)
    ) u_step (
        .cur   (state_reg),
        .kind  (kind_t'(s_axis_tuser)),
        .value (s_axis_tdata),
        .nxt   (state_next)
    );

    assign busy_next = (state_next.homing_left != '0) ||
                       (state_next.position != state_next.target);

    // Hold motor state; advance on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
                state_reg <= state_next;
            if (in_acc)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (in_acc)
            out_data_reg <= {7'b0, busy_next, state_next.target,
                             state_next.position, state_next.coil};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Position stays within full scale
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.position <= POS_W'(FULL_SCALE_STEPS))
        else $error("position beyond full scale");

    // Phase index stays within the six phases
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase <= PHASE_W'(LAST_PHASE))
        else $error("phase index out of range");

    // A home command loads the full sweep
    a_home_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser == KIND_HOME) |=>
        state_reg.homing_left == POS_W'(FULL_SCALE_STEPS))
        else $error("homing sweep not loaded");

    // A tick at target while idle leaves the state untouched
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && s_axis_tuser == KIND_TICK && state_reg.homing_left == '0 &&
         state_reg.position == state_reg.target) |=> $stable(state_reg))
        else $error("tick at target changed state");

    // A result is posted for each accepted transaction
    a_result_post: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> m_axis_tvalid)
        else $error("result missing after accept");

endmodule
`default_nettype wire
